[rtl/core/spi_mam_pkg.sv]
// Shared types and constants for the SPI memory access master.
// Used by spi_mam_ctrl, spi_mam_emit and spi_memory_access_master; no dependencies.
package spi_mam_pkg;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_START_READ  = 2'd0;
    localparam logic [1:0] CMD_START_WRITE = 2'd1;
    localparam logic [1:0] CMD_WRITE_DATA  = 2'd2;
    localparam logic [1:0] CMD_READ_DATA   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_READ_OPCODE  = 2'd0;
    localparam logic [1:0] CFG_WRITE_OPCODE = 2'd1;
    localparam logic [1:0] CFG_DUMMY_BYTES  = 2'd2;

    localparam logic [7:0] FILLER_BYTE = 8'hFF;
    localparam logic [3:0] DUMMY_RESET = 4'd4;

    // Packed widths of the stream words.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;

    // Row position inside a header sequence.
    localparam logic [2:0] ROW_OPCODE  = 3'd0;
    localparam logic [2:0] ROW_ADDR3   = 3'd1;
    localparam logic [2:0] ROW_ADDR2   = 3'd2;
    localparam logic [2:0] ROW_ADDR1   = 3'd3;
    localparam logic [2:0] ROW_ADDR0   = 3'd4;
    localparam logic [2:0] ROW_FILLER  = 3'd5;

    // Frame phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FILL  = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_WRITE = 4'b1000
    } phase_t;

    // What the result register will play out.
    typedef enum logic [1:0] {
        JOB_SINGLE    = 2'd0,
        JOB_HDR_READ  = 2'd1,
        JOB_HDR_WRITE = 2'd2
    } job_kind_t;

    // One result word, without its last mark.
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        select_active;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic [31:0] word_data;
        logic        word_valid;
        logic        done_res;
        logic [15:0] transferred;
        logic        short_request;
    } out_row_t;

    // Work handed from the control logic to the result sequencer.
    typedef struct packed {
        logic        valid;
        job_kind_t   kind;
        logic [7:0]  opcode;
        logic [31:0] address;
        out_row_t    row;
    } job_t;

endpackage

[rtl/core/spi_mam_ctrl.sv]
// Frame state, configuration registers and per-word decision logic.
// Depends on spi_mam_pkg.
module spi_mam_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_fire,
    input  logic [1:0]           command,
    input  logic [31:0]          address,
    input  logic [15:0]          byte_count,
    input  logic [7:0]           data_byte,
    output spi_mam_pkg::job_t    job
);

    logic [7:0]          read_opcode_reg;
    logic [7:0]          write_opcode_reg;
    logic [3:0]          dummy_bytes_reg;
    spi_mam_pkg::phase_t phase_reg, phase_next;
    logic [15:0]         remaining_reg, remaining_next;
    logic [15:0]         moved_reg, moved_next;
    logic [23:0]         word_shift_reg, word_shift_next;
    logic [1:0]          byte_in_word_reg, byte_in_word_next;

    logic [1:0]  skip;
    logic [1:0]  trim;
    logic [4:0]  fill;
    logic [15:0] moved_inc;
    logic [15:0] remaining_dec;
    logic [23:0] fill_dec;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_opcode_reg  <= '0;
            write_opcode_reg <= '0;
            dummy_bytes_reg  <= spi_mam_pkg::DUMMY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                spi_mam_pkg::CFG_READ_OPCODE:  read_opcode_reg  <= cfg_data;
                spi_mam_pkg::CFG_WRITE_OPCODE: write_opcode_reg <= cfg_data;
                spi_mam_pkg::CFG_DUMMY_BYTES:  dummy_bytes_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Shared arithmetic for the start and data commands.
    assign skip          = address[1:0];
    assign trim          = byte_count[1:0] + skip;
    assign fill          = {1'b0, dummy_bytes_reg} + {3'b000, skip};
    assign moved_inc     = moved_reg + 16'd1;
    assign remaining_dec = remaining_reg - 16'd1;
    assign fill_dec      = word_shift_reg - 24'd1;

    // Next state and the result job for the word presented on the input.
    always_comb
    begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        moved_next        = moved_reg;
        word_shift_next   = word_shift_reg;
        byte_in_word_next = byte_in_word_reg;
        job               = '0;
        job.kind          = spi_mam_pkg::JOB_SINGLE;
        job.address       = address;

        unique case (command)
            spi_mam_pkg::CMD_START_READ:
            begin
                if (phase_reg == spi_mam_pkg::PH_IDLE)
                begin
                    job.valid = 1'b1;
                    if (byte_count < 16'd4)
                    begin
                        job.row.done_res      = 1'b1;
                        job.row.short_request = 1'b1;
                    end
                    else
                    begin
                        job.kind          = spi_mam_pkg::JOB_HDR_READ;
                        job.opcode        = read_opcode_reg;
                        remaining_next    = byte_count - {14'd0, trim};
                        moved_next        = '0;
                        byte_in_word_next = '0;
                        word_shift_next   = {19'd0, fill};
                        phase_next        = (fill == 5'd0) ? spi_mam_pkg::PH_DATA
                                                           : spi_mam_pkg::PH_FILL;
                    end
                end
            end

            spi_mam_pkg::CMD_START_WRITE:
            begin
                if (phase_reg == spi_mam_pkg::PH_IDLE)
                begin
                    job.valid = 1'b1;
                    if (byte_count == 16'd0)
                    begin
                        job.row.done_res = 1'b1;
                    end
                    else
                    begin
                        job.kind       = spi_mam_pkg::JOB_HDR_WRITE;
                        job.opcode     = write_opcode_reg;
                        remaining_next = byte_count;
                        moved_next     = '0;
                        phase_next     = spi_mam_pkg::PH_WRITE;
                    end
                end
            end

            spi_mam_pkg::CMD_WRITE_DATA:
            begin
                if (phase_reg == spi_mam_pkg::PH_WRITE)
                begin
                    job.valid       = 1'b1;
                    job.row.tx_byte = data_byte;
                    job.row.tx_valid = 1'b1;
                    moved_next      = moved_inc;
                    remaining_next  = remaining_dec;
                    if (remaining_dec == 16'd0)
                    begin
                        job.row.done_res    = 1'b1;
                        job.row.transferred = moved_inc;
                        phase_next          = spi_mam_pkg::PH_IDLE;
                    end
                    else
                    begin
                        job.row.select_active = 1'b1;
                    end
                end
            end

            spi_mam_pkg::CMD_READ_DATA:
            begin
                if (phase_reg == spi_mam_pkg::PH_FILL)
                begin
                    job.valid             = 1'b1;
                    job.row.tx_byte       = spi_mam_pkg::FILLER_BYTE;
                    job.row.tx_valid      = 1'b1;
                    job.row.select_active = 1'b1;
                    word_shift_next       = fill_dec;
                    if (fill_dec == 24'd0)
                    begin
                        phase_next = spi_mam_pkg::PH_DATA;
                    end
                end
                else if (phase_reg == spi_mam_pkg::PH_DATA)
                begin
                    job.valid        = 1'b1;
                    job.row.rx_byte  = data_byte;
                    job.row.rx_valid = 1'b1;
                    if (byte_in_word_reg == 2'd3)
                    begin
                        job.row.word_data  = {word_shift_reg, data_byte};
                        job.row.word_valid = 1'b1;
                        word_shift_next    = '0;
                        byte_in_word_next  = '0;
                    end
                    else
                    begin
                        word_shift_next   = {word_shift_reg[15:0], data_byte};
                        byte_in_word_next = byte_in_word_reg + 2'd1;
                    end
                    moved_next     = moved_inc;
                    remaining_next = remaining_dec;
                    if (remaining_dec == 16'd0)
                    begin
                        job.row.done_res    = 1'b1;
                        job.row.transferred = moved_inc;
                        phase_next          = spi_mam_pkg::PH_IDLE;
                        word_shift_next     = '0;
                        byte_in_word_next   = '0;
                    end
                    else
                    begin
                        job.row.tx_byte       = spi_mam_pkg::FILLER_BYTE;
                        job.row.tx_valid      = 1'b1;
                        job.row.select_active = 1'b1;
                    end
                end
            end

            default: ;
        endcase
    end

    // Frame state advances only on an accepted input word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= spi_mam_pkg::PH_IDLE;
            remaining_reg    <= '0;
            moved_reg        <= '0;
            word_shift_reg   <= '0;
            byte_in_word_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            moved_reg        <= moved_next;
            word_shift_reg   <= word_shift_next;
            byte_in_word_reg <= byte_in_word_next;
        end
    end

endmodule

[rtl/core/spi_mam_emit.sv]
// Result register and row sequencer: plays out one job as one or more result words.
// Depends on spi_mam_pkg.
module spi_mam_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  spi_mam_pkg::job_t     job_in,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_last,
    output spi_mam_pkg::out_row_t out_row,
    output logic                  free_next
);

    logic              valid_reg;
    logic [2:0]        idx_reg;
    spi_mam_pkg::job_t job_reg;
    logic              out_fire;

    assign out_valid = valid_reg;
    assign out_fire  = valid_reg && out_ready;
    // The register can take a new job when empty or when its final word leaves now.
    assign free_next = !valid_reg || (out_fire && out_last);

    // Build the current row from the held job and the row position.
    always_comb
    begin
        out_row  = '0;
        out_last = 1'b0;
        case (job_reg.kind)
            spi_mam_pkg::JOB_HDR_READ,
            spi_mam_pkg::JOB_HDR_WRITE:
            begin
                out_row.tx_valid      = 1'b1;
                out_row.select_active = 1'b1;
                case (idx_reg)
                    spi_mam_pkg::ROW_OPCODE: out_row.tx_byte = job_reg.opcode;
                    spi_mam_pkg::ROW_ADDR3:  out_row.tx_byte = job_reg.address[31:24];
                    spi_mam_pkg::ROW_ADDR2:  out_row.tx_byte = job_reg.address[23:16];
                    spi_mam_pkg::ROW_ADDR1:  out_row.tx_byte = job_reg.address[15:8];
                    spi_mam_pkg::ROW_ADDR0:  out_row.tx_byte = job_reg.address[7:0];
                    default:                 out_row.tx_byte = spi_mam_pkg::FILLER_BYTE;
                endcase
                if (job_reg.kind == spi_mam_pkg::JOB_HDR_READ)
                begin
                    out_last = (idx_reg == spi_mam_pkg::ROW_FILLER);
                end
                else
                begin
                    out_last = (idx_reg == spi_mam_pkg::ROW_ADDR0);
                end
            end
            default:
            begin
                out_row  = job_reg.row;
                out_last = 1'b1;
            end
        endcase
    end

    // Control: occupancy and row position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (out_last)
            begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Payload of the held job.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
    end

endmodule

[rtl/core/spi_memory_access_master.sv]
// Top level of the SPI memory access master: stream ports, config port and word packing.
// Depends on spi_mam_pkg, spi_mam_ctrl and spi_mam_emit.

// An input word is taken whenever the result register is empty or its final result word
// is taken in the same cycle, so data and received-byte commands, which give one result
// word each, run at one word per clock while the output is ready. A start-read plays out
// six result words (opcode, four address bytes, first filler) and a start-write five, one
// per clock while the output is ready, and the input waits until the last of them leaves;
// ignored commands are taken but give no result. Configuration writes are always accepted
// and must be issued only while no transfer result is pending.
module spi_memory_access_master
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [7:0]                          cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // address [31:0], byte_count [47:32], data_byte [55:48]
    input  logic [spi_mam_pkg::IN_DATA_W-1:0]   s_tdata,
    // command [1:0]
    input  logic [1:0]                          s_tuser,
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tx_byte [7:0], tx_valid [8], select_active [9], rx_byte [17:10], rx_valid [18],
    // word_data [50:19], word_valid [51], done_res [52], transferred [68:53],
    // short_request [69], zero [71:70]
    output logic [spi_mam_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                                m_tlast
);

    spi_mam_pkg::job_t     job;
    spi_mam_pkg::out_row_t row;
    logic                  in_fire;
    logic                  free_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = free_next;
    assign in_fire   = s_tvalid && s_tready;

    // Frame state and per-word decisions.
    spi_mam_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .command    (s_tuser),
        .address    (s_tdata[31:0]),
        .byte_count (s_tdata[47:32]),
        .data_byte  (s_tdata[55:48]),
        .job        (job)
    );

    // Result register and row sequencing.
    spi_mam_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && job.valid),
        .job_in    (job),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_row   (row),
        .free_next (free_next)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_tdata = {2'b00,
                      row.short_request,
                      row.transferred,
                      row.done_res,
                      row.word_valid,
                      row.word_data,
                      row.rx_valid,
                      row.rx_byte,
                      row.select_active,
                      row.tx_valid,
                      row.tx_byte};

endmodule

[sim/testbench.sv]
// Self-checking testbench for spi_memory_access_master: stream stimulus, a cycle-free
// model of the frame engine and a word-by-word scoreboard of the result stream.
// Depends on spi_mam_pkg and the spi_memory_access_master RTL.
`timescale 1ns / 1ps

module testbench;

    import spi_mam_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_BOUND   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 250;

    // One input word as the sender sees it.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [15:0] cnt;
        logic [7:0]  dat;
    } req_t;

    // One result word as the receiver should see it.
    typedef struct packed {
        out_row_t row;
        logic     tail;
    } link_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [7:0]            cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    req_t      cmd_pending[$];
    link_row_t rows_due[$];

    // Model copy of the block's registers and frame state.
    logic [7:0]  rd_op = 8'h00;
    logic [7:0]  wr_op = 8'h00;
    logic [3:0]  dummy_n = DUMMY_RESET;
    phase_t      ph = PH_IDLE;
    logic [15:0] rem_cnt = '0;
    logic [15:0] moved_cnt = '0;
    logic [23:0] shift_reg = '0;
    logic [1:0]  byte_idx = '0;

    // Generator view of the dummy setting, used to size read frames.
    logic [3:0]  gen_dummy = DUMMY_RESET;

    int   err_cnt = 0;
    int   in_cnt = 0;
    int   rows_seen = 0;
    int   cfg_taken = 0;
    int   settings_cnt = 1;
    int   items_queued = 0;
    int   cycle_cnt = 0;
    int   quiet[2] = '{0, 0};
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_used = 1'b0;
    logic in_taken = 1'b0;

    spi_memory_access_master dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    // Gap length for one side: mostly none or short, sometimes long, with quiet stretches.
    function automatic int pick_gap(input int side);
        int r;
        if (quiet[side] > 0)
        begin
            quiet[side] = quiet[side] - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet[side] = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function void queue_row(input logic [7:0] tx, input logic txv, input logic sel,
                            input logic [7:0] rx, input logic rxv, input logic [31:0] wd,
                            input logic wv, input logic dn, input logic [15:0] xfer,
                            input logic shrt, input logic tail);
        link_row_t r;
        r.row.tx_byte       = tx;
        r.row.tx_valid      = txv;
        r.row.select_active = sel;
        r.row.rx_byte       = rx;
        r.row.rx_valid      = rxv;
        r.row.word_data     = wd;
        r.row.word_valid    = wv;
        r.row.done_res      = dn;
        r.row.transferred   = xfer;
        r.row.short_request = shrt;
        r.tail              = tail;
        rows_due.push_back(r);
    endfunction

    // Opcode and the four address bytes, most significant first.
    function void queue_header(input logic [7:0] op, input logic [31:0] a, input logic tail);
        queue_row(op, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_row(a[31:24], 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_row(a[23:16], 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_row(a[15:8], 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_row(a[7:0], 1, 1, 0, 0, 0, 0, 0, 0, 0, tail);
    endfunction

    // Works out the result words that one accepted input word causes.
    function void predict_link_rows(input logic [1:0] cmd, input logic [31:0] a,
                                    input logic [15:0] n, input logic [7:0] d);
        logic [1:0]  skip;
        logic [1:0]  trim;
        logic [4:0]  fill;
        logic [31:0] wd;
        logic        wv;
        case (cmd)
            CMD_START_READ:
            begin
                if (ph == PH_IDLE)
                begin
                    if (n < 16'd4)
                        queue_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1);
                    else
                    begin
                        skip      = a[1:0];
                        trim      = n[1:0] + skip;
                        fill      = {1'b0, dummy_n} + {3'b000, skip};
                        rem_cnt   = n - {14'd0, trim};
                        moved_cnt = '0;
                        byte_idx  = '0;
                        queue_header(rd_op, a, 0);
                        queue_row(FILLER_BYTE, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1);
                        if (fill == 5'd0)
                        begin
                            ph        = PH_DATA;
                            shift_reg = '0;
                        end
                        else
                        begin
                            ph        = PH_FILL;
                            shift_reg = {19'd0, fill};
                        end
                    end
                end
            end
            CMD_START_WRITE:
            begin
                if (ph == PH_IDLE)
                begin
                    if (n == 16'd0)
                        queue_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
                    else
                    begin
                        rem_cnt   = n;
                        moved_cnt = '0;
                        ph        = PH_WRITE;
                        queue_header(wr_op, a, 1);
                    end
                end
            end
            CMD_WRITE_DATA:
            begin
                if (ph == PH_WRITE)
                begin
                    moved_cnt = moved_cnt + 16'd1;
                    rem_cnt   = rem_cnt - 16'd1;
                    if (rem_cnt == 16'd0)
                    begin
                        queue_row(d, 1, 0, 0, 0, 0, 0, 1, moved_cnt, 0, 1);
                        ph = PH_IDLE;
                    end
                    else
                        queue_row(d, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1);
                end
            end
            default:
            begin
                if (ph == PH_FILL)
                begin
                    shift_reg = shift_reg - 24'd1;
                    if (shift_reg == 24'd0)
                        ph = PH_DATA;
                    queue_row(FILLER_BYTE, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1);
                end
                else if (ph == PH_DATA)
                begin
                    wd = '0;
                    wv = 1'b0;
                    // Fourth byte closes a big-endian word.
                    if (byte_idx == 2'd3)
                    begin
                        wd        = {shift_reg, d};
                        wv        = 1'b1;
                        shift_reg = '0;
                        byte_idx  = '0;
                    end
                    else
                    begin
                        shift_reg = {shift_reg[15:0], d};
                        byte_idx  = byte_idx + 2'd1;
                    end
                    moved_cnt = moved_cnt + 16'd1;
                    rem_cnt   = rem_cnt - 16'd1;
                    if (rem_cnt == 16'd0)
                    begin
                        queue_row(0, 0, 0, d, 1, wd, wv, 1, moved_cnt, 0, 1);
                        ph        = PH_IDLE;
                        shift_reg = '0;
                        byte_idx  = '0;
                    end
                    else
                        queue_row(FILLER_BYTE, 1, 1, d, 1, wd, wv, 0, 0, 0, 1);
                end
            end
        endcase
    endfunction

    task cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Sender: offers queued words at the falling edge and holds each until it is taken.
    always @(negedge clk)
    begin : driver
        req_t it;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_pending.size() > 0)
            begin
                it = cmd_pending.pop_front();
                s_tuser  <= it.cmd;
                s_tdata  <= {it.dat, it.cnt, it.addr};
                s_tvalid <= 1'b1;
                gap_left <= pick_gap(0);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off once traffic is under way.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && rows_seen >= HOLD_AFTER)
        begin
            m_tready  <= 1'b0;
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap(1);
        end
    end

    // Monitor: applies register writes, predicts accepted words and checks results.
    always @(posedge clk)
    begin : monitor
        link_row_t e;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_READ_OPCODE:  rd_op = cfg_data;
                    CFG_WRITE_OPCODE: wr_op = cfg_data;
                    CFG_DUMMY_BYTES:  dummy_n = cfg_data[3:0];
                    default: ;
                endcase
                cfg_taken++;
            end
            if (s_tvalid && s_tready)
            begin
                in_cnt++;
                predict_link_rows(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[55:48]);
            end
            if (m_tvalid && m_tready)
            begin
                rows_seen++;
                if (rows_due.size() == 0)
                begin
                    $error("result word 0x%0h arrived with none expected", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    e = rows_due.pop_front();
                    cmp_field("tx_byte", e.row.tx_byte, m_tdata[7:0]);
                    cmp_field("tx_valid", e.row.tx_valid, m_tdata[8]);
                    cmp_field("select_active", e.row.select_active, m_tdata[9]);
                    cmp_field("rx_byte", e.row.rx_byte, m_tdata[17:10]);
                    cmp_field("rx_valid", e.row.rx_valid, m_tdata[18]);
                    cmp_field("word_data", e.row.word_data, m_tdata[50:19]);
                    cmp_field("word_valid", e.row.word_valid, m_tdata[51]);
                    cmp_field("done_res", e.row.done_res, m_tdata[52]);
                    cmp_field("transferred", e.row.transferred, m_tdata[68:53]);
                    cmp_field("short_request", e.row.short_request, m_tdata[69]);
                    cmp_field("pad", 0, m_tdata[71:70]);
                    cmp_field("last", e.tail, m_tlast);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task add_item(input logic [1:0] c, input logic [31:0] a, input logic [15:0] n,
                  input logic [7:0] d);
        req_t it;
        it.cmd  = c;
        it.addr = a;
        it.cnt  = n;
        it.dat  = d;
        cmd_pending.push_back(it);
        items_queued++;
    endtask

    // A command the block must drop: a start while busy, or data for the other direction.
    task add_noise(input bit in_read);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            add_item(in_read ? CMD_WRITE_DATA : CMD_READ_DATA, $urandom, $urandom, $urandom);
        else
            add_item(r == 1 ? CMD_START_READ : CMD_START_WRITE, $urandom, $urandom, $urandom);
    endtask

    // Start-read followed by one received-byte word per filler and kept byte.
    task add_read_frame(input logic [31:0] a, input logic [15:0] n, input bit noisy);
        int          total;
        logic [1:0]  trim;
        trim  = n[1:0] + a[1:0];
        total = int'(gen_dummy) + int'(a[1:0]) + int'(n) - int'(trim);
        add_item(CMD_START_READ, a, n, $urandom);
        for (int i = 0; i < total; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                add_noise(1'b1);
            add_item(CMD_READ_DATA, $urandom, $urandom, $urandom);
        end
    endtask

    task add_write_frame(input logic [31:0] a, input logic [15:0] n, input bit noisy);
        add_item(CMD_START_WRITE, a, n, $urandom);
        for (int i = 0; i < int'(n); i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                add_noise(1'b0);
            add_item(CMD_WRITE_DATA, $urandom, $urandom, $urandom);
        end
    endtask

    task run_random(input int n);
        int          start;
        int          r;
        logic [31:0] a;
        logic [15:0] len;
        start = items_queued;
        while (items_queued - start < n)
        begin
            r = $urandom_range(0, 99);
            a = $urandom;
            if (r < 38)
            begin
                len = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(21, 48))
                                                  : 16'($urandom_range(4, 20));
                add_read_frame(a, len, 1'b1);
            end
            else if (r < 66)
            begin
                len = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(17, 48))
                                                  : 16'($urandom_range(1, 16));
                add_write_frame(a, len, 1'b1);
            end
            else if (r < 76)
                add_item(CMD_START_READ, a, 16'($urandom_range(0, 3)), $urandom);
            else if (r < 82)
                add_item(CMD_START_WRITE, a, 16'd0, $urandom);
            else
                add_item($urandom_range(0, 1) ? CMD_WRITE_DATA : CMD_READ_DATA, a, $urandom,
                         $urandom);
        end
    endtask

    task write_reg(input logic [1:0] idx, input logic [7:0] val);
        int seen;
        @(negedge clk);
        seen = cfg_taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (cfg_taken == seen);
        cfg_valid <= 1'b0;
    endtask

    task set_config(input logic [7:0] ro, input logic [7:0] wo, input logic [3:0] dm);
        write_reg(CFG_READ_OPCODE, ro);
        write_reg(CFG_WRITE_OPCODE, wo);
        write_reg(CFG_DUMMY_BYTES, {4'd0, dm});
        gen_dummy = dm;
        settings_cnt++;
    endtask

    // Waits until every queued word is taken and every result is in, then lets the
    // block settle so that dropped commands have left it too.
    task wait_idle;
        int spent;
        spent = 0;
        do
        begin
            @(negedge clk);
            spent++;
        end
        while ((cmd_pending.size() != 0 || s_tvalid || rows_due.size() != 0)
               && spent < DRAIN_BOUND);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: short reads, empty write, stray data, busy start.
        add_item(CMD_START_READ, 32'h0000_0000, 16'd0, 8'h00);
        add_item(CMD_START_READ, 32'hFFFF_FFFF, 16'd3, 8'hFF);
        add_item(CMD_START_WRITE, 32'hFFFF_FFFF, 16'd0, 8'h00);
        add_item(CMD_WRITE_DATA, 32'h0000_0000, 16'd0, 8'hFF);
        add_item(CMD_READ_DATA, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
        add_item(CMD_START_WRITE, 32'hFFFF_FFFF, 16'd1, 8'h00);
        add_item(CMD_START_READ, 32'h0000_0000, 16'hFFFF, 8'h00);
        add_item(CMD_READ_DATA, 32'h0000_0000, 16'd0, 8'h12);
        add_item(CMD_WRITE_DATA, 32'h0000_0000, 16'd0, 8'hFF);
        add_read_frame(32'h0000_0000, 16'd4, 1'b0);
        wait_idle();

        // No dummy bytes: an unaligned read ending in a dropped partial word, and an
        // aligned read that goes straight to data.
        set_config(8'hFF, 8'hFF, 4'd0);
        add_read_frame(32'h8000_0005, 16'd4, 1'b0);
        add_read_frame(32'h7FFF_FFFC, 16'd5, 1'b0);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       set_config($urandom, $urandom, 4'd15);
                2:       set_config(8'h00, 8'hFF, 4'd0);
                4:       set_config(8'hFF, 8'h00, 4'd15);
                default: set_config($urandom, $urandom, $urandom);
            endcase
            run_random(60);
            wait_idle();
        end

        // A long read that stays open: later starts are dropped while it runs.
        add_item(CMD_START_READ, $urandom, 16'($urandom_range(32768, 65535)), $urandom);
        repeat (20)
        begin
            if ($urandom_range(0, 3) == 0)
                add_noise(1'b1);
            add_item(CMD_READ_DATA, $urandom, $urandom, $urandom);
        end
        wait_idle();

        if (rows_due.size() != 0)
        begin
            $error("%0d expected result words never arrived", rows_due.size());
            err_cnt++;
        end
        $display("Covered %0d input words and %0d result words over %0d register settings.",
                 in_cnt, rows_seen, settings_cnt);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
